>>> sv/sia_pkg.sv
// Shared types and codes for the signed integer ALU.
package sia_pkg;
    localparam int unsigned DataW = 64;
    localparam int unsigned KindW = 3;
    localparam int unsigned StatW = 2;

    localparam logic [KindW-1:0] KIND_ADD = 3'd0;
    localparam logic [KindW-1:0] KIND_SUB = 3'd1;
    localparam logic [KindW-1:0] KIND_MUL = 3'd2;
    localparam logic [KindW-1:0] KIND_DIV = 3'd3;
    localparam logic [KindW-1:0] KIND_REM = 3'd4;
    localparam logic [KindW-1:0] KIND_NEG = 3'd5;

    localparam logic [StatW-1:0] STAT_OK       = 2'd0;
    localparam logic [StatW-1:0] STAT_DIV_ZERO = 2'd1;
    localparam logic [StatW-1:0] STAT_OVERFLOW = 2'd2;

    localparam logic [DataW-1:0] INT_MIN = {1'b1, {(DataW-1){1'b0}}};

    // Classified word between the front and the back end.
    typedef struct packed {
        logic [KindW-1:0] kind;
        logic             trap;
        logic [StatW-1:0] status;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
    } t_op;

    // Queue control seen by the back end.
    typedef struct packed {
        logic valid;
        logic take;
    } t_qctl;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw    = $clog2(QDepth);

    // Back-end pipeline depth: stage 0, one divide step per stage (64), plus the sign-fix stage.
    localparam int unsigned DivSteps = DataW;
    localparam int unsigned PipeLen  = DivSteps + 2;
    localparam int unsigned PipeCntW = $clog2(PipeLen + 4);
    // Output queue must hold everything in flight.
    localparam int unsigned OQDepth = 128;
    localparam int unsigned OQAw    = $clog2(OQDepth);
endpackage

>>> sv/sia_front.sv
// Front end: accepts words, classifies traps, and queues them for the back end.
module sia_front import sia_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [KindW-1:0] i_kind,
    input  logic [DataW-1:0] i_operand_a,
    input  logic [DataW-1:0] i_operand_b,
    input  logic             i_take,
    output logic             o_valid,
    output t_op              o_op
);
    t_op            r_mem [QDepth];
    logic [QAw-1:0] r_rd;
    logic [QAw-1:0] r_wr;
    logic [QAw:0]   r_cnt;
    t_op            n_op;
    logic           w_is_div;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_cnt == (QAw+1)'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_comb begin
        w_is_div  = (i_kind == KIND_DIV) || (i_kind == KIND_REM);
        n_op.kind = i_kind;
        n_op.a    = i_operand_a;
        n_op.b    = i_operand_b;
        n_op.trap = 1'b0;
        n_op.status = STAT_OK;
        if (w_is_div && i_operand_b == '0) begin
            n_op.trap   = 1'b1;
            n_op.status = STAT_DIV_ZERO;
        end else if (w_is_div && i_operand_a == INT_MIN && i_operand_b == '1) begin
            n_op.trap   = 1'b1;
            n_op.status = STAT_OVERFLOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QAw+1)'(w_push) - (QAw+1)'(w_pop);
        end
    end
endmodule

>>> sv/sia_back.sv
// Back end: pipelined arithmetic with a one-bit-per-stage divider.
module sia_back import sia_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_qctl            i_ctl,
    input  t_op              i_op,
    output logic             o_valid,
    output logic [DataW-1:0] o_value,
    output logic [StatW-1:0] o_status
);
    // Stage 0: magnitudes and the simple results; multiply split into halves.
    localparam int unsigned HW = DataW / 2;

    logic [DivSteps:0]  r_v;
    logic [DataW-1:0]   r_rem [DivSteps+1];
    logic [DataW-1:0]   r_quo [DivSteps+1];
    logic [DataW-1:0]   r_den [DivSteps+1];
    logic [DataW-1:0]   r_res [DivSteps+1];
    logic [KindW-1:0]   r_kind [DivSteps+1];
    logic [StatW-1:0]   r_st [DivSteps+1];
    logic               r_trap [DivSteps+1];
    logic               r_nq [DivSteps+1];
    logic               r_nr [DivSteps+1];
    logic [DataW-1:0]   r_pll;
    logic [DataW-1:0]   r_plh;
    logic [DataW-1:0]   r_phl;
    logic               r_ov;
    logic [DataW-1:0]   r_oval;
    logic [StatW-1:0]   r_ost;

    logic               w_na;
    logic               w_nb;
    logic [DataW-1:0]   w_ma;
    logic [DataW-1:0]   w_mb;
    logic [DataW-1:0]   w_simple;

    always_comb begin
        w_na = i_op.a[DataW-1];
        w_nb = i_op.b[DataW-1];
        w_ma = w_na ? (DataW)'(-i_op.a) : i_op.a;
        w_mb = w_nb ? (DataW)'(-i_op.b) : i_op.b;
        case (i_op.kind)
            KIND_ADD: w_simple = i_op.a + i_op.b;
            KIND_SUB: w_simple = i_op.a - i_op.b;
            KIND_NEG: w_simple = (DataW)'(-i_op.a);
            default:  w_simple = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_quo[0]  <= w_ma;
        r_den[0]  <= w_mb;
        r_res[0]  <= w_simple;
        r_kind[0] <= i_op.kind;
        r_st[0]   <= i_op.status;
        r_trap[0] <= i_op.trap;
        r_nq[0]   <= w_na ^ w_nb;
        r_nr[0]   <= w_na;
        r_pll     <= i_op.a[HW-1:0] * i_op.b[HW-1:0];
        r_plh     <= i_op.a[HW-1:0] * i_op.b[DataW-1:HW];
        r_phl     <= i_op.a[DataW-1:HW] * i_op.b[HW-1:0];
    end

    // Restoring divide: each stage shifts in one dividend bit.
    for (genvar s = 0; s < DivSteps; s++) begin : g_div
        logic [DataW:0]   w_tr;
        logic [DataW:0]   w_df;
        logic [DataW-1:0] w_res;
        always_comb begin
            w_tr  = {r_rem[s], r_quo[s][DataW-1]};
            w_df  = w_tr - {1'b0, r_den[s]};
            w_res = r_res[s];
            // Multiply partial products are registered at stage 0; combine next.
            if (s == 0 && r_kind[s] == KIND_MUL) begin
                w_res = r_pll + {r_plh[HW-1:0] + r_phl[HW-1:0], {HW{1'b0}}};
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_df[DataW]) begin
                r_rem[s+1] <= w_tr[DataW-1:0];
                r_quo[s+1] <= {r_quo[s][DataW-2:0], 1'b0};
            end else begin
                r_rem[s+1] <= w_df[DataW-1:0];
                r_quo[s+1] <= {r_quo[s][DataW-2:0], 1'b1};
            end
            r_den[s+1]  <= r_den[s];
            r_res[s+1]  <= w_res;
            r_kind[s+1] <= r_kind[s];
            r_st[s+1]   <= r_st[s];
            r_trap[s+1] <= r_trap[s];
            r_nq[s+1]   <= r_nq[s];
            r_nr[s+1]   <= r_nr[s];
        end
    end

    logic [DataW-1:0] w_fin;
    always_comb begin
        case (r_kind[DivSteps])
            KIND_DIV: w_fin = r_nq[DivSteps] ? (DataW)'(-r_quo[DivSteps]) : r_quo[DivSteps];
            KIND_REM: w_fin = r_nr[DivSteps] ? (DataW)'(-r_rem[DivSteps]) : r_rem[DivSteps];
            default:  w_fin = r_res[DivSteps];
        endcase
        if (r_trap[DivSteps]) begin
            w_fin = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oval <= w_fin;
        r_ost  <= r_st[DivSteps];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            r_v  <= {r_v[DivSteps-1:0], i_ctl.valid && i_ctl.take};
            r_ov <= r_v[DivSteps];
        end
    end

    assign o_valid  = r_ov;
    assign o_value  = r_oval;
    assign o_status = r_ost;
endmodule

>>> sv/sia_outq.sv
// Result queue: holds back-end words until popped.
module sia_outq import sia_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [DataW-1:0] i_value,
    input  logic [StatW-1:0] i_status,
    input  logic             i_pop,
    output logic             o_empty,
    output logic             o_room,
    output logic [DataW-1:0] o_value,
    output logic [StatW-1:0] o_status
);
    logic [DataW+StatW-1:0] r_mem [OQDepth];
    logic [OQAw-1:0]        r_wr;
    logic [OQAw-1:0]        r_rd;
    logic [OQAw:0]          r_cnt;
    logic [DataW+StatW-1:0] r_head;
    logic                   r_hv;
    logic                   w_mem_ne;
    logic                   w_ld;
    logic                   w_pop;

    // The memory read is registered into a head stage that drives the ports.
    assign w_pop    = i_pop && r_hv;
    assign w_mem_ne = (r_cnt != '0);
    assign w_ld     = w_mem_ne && (!r_hv || w_pop);
    assign o_empty  = !r_hv;
    assign o_value  = r_head[DataW+StatW-1:StatW];
    assign o_status = r_head[StatW-1:0];
    assign o_room   = (r_cnt < (OQAw+1)'(OQDepth - PipeLen - 8));

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr] <= {i_value, i_status};
        end
        if (w_ld) begin
            r_head <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_hv  <= 1'b0;
        end else begin
            if (i_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_ld) begin
                r_rd <= r_rd + 1'b1;
                r_hv <= 1'b1;
            end else if (w_pop) begin
                r_hv <= 1'b0;
            end
            r_cnt <= r_cnt + (OQAw+1)'(i_wr) - (OQAw+1)'(w_ld);
        end
    end
endmodule

>>> sv/signed_integer_alu_with_traps.sv
// A pushed word reaches the result port through the input queue, the 66 back-end stages,
// and the write and head load in the result queue.
// Throughput: one word per cycle while results are popped; the 64-stage divider pipeline
// takes new words while earlier ones are in flight, and only the result queue credit holds the flow.
// Reset (synchronous, active low) empties both queues and the pipeline valid bits.
// Divide and remainder take one quotient bit per stage.
module signed_integer_alu_with_traps import sia_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [KindW-1:0] i_kind,
    input  logic [DataW-1:0] i_operand_a,
    input  logic [DataW-1:0] i_operand_b,
    output logic             empty,
    input  logic             pop,
    output logic [DataW-1:0] o_value,
    output logic [StatW-1:0] o_status
);
    t_op              w_op;
    t_qctl            w_ctl;
    logic             w_room;
    logic             w_fvalid;
    logic             w_bv;
    logic [DataW-1:0] w_bval;
    logic [StatW-1:0] w_bst;

    assign w_ctl = '{valid: w_fvalid, take: w_room};

    sia_front u_front (
        .i_clk, .i_rst_n,
        .i_push(push), .o_full(full),
        .i_kind, .i_operand_a, .i_operand_b,
        .i_take(w_room), .o_valid(w_fvalid), .o_op(w_op)
    );

    sia_back u_back (
        .i_clk, .i_rst_n,
        .i_ctl(w_ctl), .i_op(w_op),
        .o_valid(w_bv), .o_value(w_bval), .o_status(w_bst)
    );

    sia_outq u_outq (
        .i_clk, .i_rst_n,
        .i_wr(w_bv), .i_value(w_bval), .i_status(w_bst),
        .i_pop(pop), .o_empty(empty), .o_room(w_room),
        .o_value, .o_status
    );

    a_trap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != STAT_OK) |-> (o_value == '0))
        else $error("trap result not zero");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status == STAT_OK || o_status == STAT_DIV_ZERO ||
                    o_status == STAT_OVERFLOW))
        else $error("bad status code");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_value) && $stable(o_status)))
        else $error("result changed while waiting");
endmodule
